// ===== sv/bbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbfe_pkg
// Shared constants, codes and controller/datapath interface types of the
// blob base fee exponential unit.
// ----------------------------------------------------------------------------
package bbfe_pkg;

  // data widths
  localparam int DATA_W    = 64;
  localparam int HALF_W    = DATA_W / 2;
  localparam int DIV_CNT_W = $clog2(DATA_W);
  localparam int CFG_IDX_W = 8;

  // series term limit and counter width
  localparam int MAX_TERMS  = 256;
  localparam int TERM_CNT_W = $clog2(MAX_TERMS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = CFG_IDX_W'(1);

  // register reset values
  localparam logic [DATA_W-1:0] FACTOR_RESET        = DATA_W'(1);
  localparam logic [DATA_W-1:0] FEE_UPDATE_FRACTION = DATA_W'(3338477);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TERM_LIMIT = 2'd1,
    STATUS_ZERO_DIV   = 2'd2
  } status_e;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_FACTOR_DEN,
    MUL_QUO_NUM,
    MUL_REM_NUM
  } mul_sel_e;

  // divider operand pairs
  typedef enum logic [1:0] {
    DIV_TERM_D,
    DIV_PROD_D,
    DIV_SUM_DEN
  } div_sel_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_CHECK,
    ST_TEST_D,
    ST_DIV_Q,
    ST_MUL_Q,
    ST_MUL_R,
    ST_DIV_R,
    ST_DIV_SUM,
    ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_num;
    logic     clear_series;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     term_from_mul;
    logic     step;
    logic     pq_load;
    logic     term_from_next;
    logic     out_load;
    status_e  out_status;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic den_zero;
    logic term_zero;
    logic d_zero;
    logic k_max;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== sv/bbfe_div.sv =====
// ----------------------------------------------------------------------------
// bbfe_div
// Restoring radix-2 divider, one quotient bit per cycle. Quotient and
// remainder hold until the next start.
// ----------------------------------------------------------------------------
module bbfe_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bbfe_pkg::DATA_W-1:0] dividend_i,
  input  logic [bbfe_pkg::DATA_W-1:0] divisor_i,
  output logic [bbfe_pkg::DATA_W-1:0] quotient_o,
  output logic [bbfe_pkg::DATA_W-1:0] remainder_o,
  output logic                        done_o
);

  localparam logic [bbfe_pkg::DIV_CNT_W-1:0] LastStep =
    bbfe_pkg::DIV_CNT_W'(bbfe_pkg::DATA_W - 1);

  logic [bbfe_pkg::DATA_W-1:0]    quo_q, quo_d;
  logic [bbfe_pkg::DATA_W-1:0]    rem_q, rem_d;
  logic [bbfe_pkg::DATA_W-1:0]    dvs_q;
  logic [bbfe_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic [bbfe_pkg::DATA_W:0]      shifted;
  logic [bbfe_pkg::DATA_W:0]      diff;
  logic                           fits;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[bbfe_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? diff[bbfe_pkg::DATA_W-1:0] : shifted[bbfe_pkg::DATA_W-1:0];
    quo_d   = {quo_q[bbfe_pkg::DATA_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + bbfe_pkg::DIV_CNT_W'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// ===== sv/bbfe_mul.sv =====
// ----------------------------------------------------------------------------
// bbfe_mul
// Low half of a 64 by 64 product from three 32 by 32 partial products,
// one per cycle, each registered before it is accumulated.
// ----------------------------------------------------------------------------
module bbfe_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bbfe_pkg::DATA_W-1:0] a_i,
  input  logic [bbfe_pkg::DATA_W-1:0] b_i,
  output logic [bbfe_pkg::DATA_W-1:0] product_o,
  output logic                        done_o
);

  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepLoHi = 2'd1;
  localparam logic [1:0] StepHiLo = 2'd2;
  localparam logic [1:0] StepLast = 2'd3;

  logic [bbfe_pkg::DATA_W-1:0] a_q, b_q;
  logic [bbfe_pkg::DATA_W-1:0] prod_q;
  logic [bbfe_pkg::DATA_W-1:0] acc_q;
  logic [1:0]                  step_q;
  logic                        busy_q, done_q;
  logic [bbfe_pkg::HALF_W-1:0] pa, pb;
  logic [bbfe_pkg::HALF_W-1:0] acc_hi;

  // partial operand select
  always_comb begin
    unique case (step_q)
      StepLoLo: begin
        pa = a_q[bbfe_pkg::HALF_W-1:0];
        pb = b_q[bbfe_pkg::HALF_W-1:0];
      end
      StepLoHi: begin
        pa = a_q[bbfe_pkg::HALF_W-1:0];
        pb = b_q[bbfe_pkg::DATA_W-1:bbfe_pkg::HALF_W];
      end
      default: begin
        pa = a_q[bbfe_pkg::DATA_W-1:bbfe_pkg::HALF_W];
        pb = b_q[bbfe_pkg::HALF_W-1:0];
      end
    endcase
    acc_hi = acc_q[bbfe_pkg::DATA_W-1:bbfe_pkg::HALF_W] + prod_q[bbfe_pkg::HALF_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= StepLoLo;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepLoLo;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == StepLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      prod_q <= bbfe_pkg::DATA_W'(pa) * bbfe_pkg::DATA_W'(pb);
      if (step_q == StepLoHi) begin
        acc_q <= prod_q;
      end else if (step_q == StepHiLo || step_q == StepLast) begin
        acc_q <= {acc_hi, acc_q[bbfe_pkg::HALF_W-1:0]};
      end
    end
  end

  assign product_o = acc_q;
  assign done_o    = done_q;

endmodule

// ===== sv/bbfe_dpath.sv =====
// ----------------------------------------------------------------------------
// bbfe_dpath
// Series datapath: configuration registers, term, sum, term divisor and
// count, the shared multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
module bbfe_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbfe_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic [bbfe_pkg::DATA_W-1:0]    num_i,
  input  bbfe_pkg::dp_cmd_t              cmd_i,
  output bbfe_pkg::dp_stat_t             stat_o,
  output logic [bbfe_pkg::DATA_W-1:0]    value_o,
  output logic [1:0]                     status_o
);

  logic [bbfe_pkg::DATA_W-1:0]     factor_q, den_q;
  logic [bbfe_pkg::DATA_W-1:0]     num_q, term_q, sum_q, d_q, pq_q;
  logic [bbfe_pkg::TERM_CNT_W-1:0] k_q;
  logic [bbfe_pkg::DATA_W-1:0]     value_q;
  bbfe_pkg::status_e               status_q;
  logic [bbfe_pkg::DATA_W-1:0]     mul_a, mul_b, mul_p;
  logic [bbfe_pkg::DATA_W-1:0]     div_a, div_b, div_quo, div_rem;
  logic                            mul_done, div_done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= bbfe_pkg::FACTOR_RESET;
      den_q    <= bbfe_pkg::FEE_UPDATE_FRACTION;
    end else if (cfg_we_i) begin
      if (cfg_index_i == bbfe_pkg::REG_FACTOR) begin
        factor_q <= cfg_data_i;
      end else if (cfg_index_i == bbfe_pkg::REG_DIVISOR) begin
        den_q <= cfg_data_i;
      end
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      bbfe_pkg::MUL_FACTOR_DEN: begin
        mul_a = factor_q;
        mul_b = den_q;
      end
      bbfe_pkg::MUL_QUO_NUM: begin
        mul_a = div_quo;
        mul_b = num_q;
      end
      default: begin
        mul_a = div_rem;
        mul_b = num_q;
      end
    endcase
  end

  // divider operand select
  always_comb begin
    unique case (cmd_i.div_sel)
      bbfe_pkg::DIV_TERM_D: begin
        div_a = term_q;
        div_b = d_q;
      end
      bbfe_pkg::DIV_PROD_D: begin
        div_a = mul_p;
        div_b = d_q;
      end
      default: begin
        div_a = sum_q;
        div_b = den_q;
      end
    endcase
  end

  bbfe_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .product_o (mul_p),
    .done_o    (mul_done)
  );

  bbfe_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // series registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_num) begin
      num_q <= num_i;
    end
    if (cmd_i.clear_series) begin
      sum_q <= '0;
      d_q   <= '0;
      k_q   <= '0;
    end else if (cmd_i.step) begin
      sum_q <= sum_q + term_q;
      d_q   <= d_q + den_q;
      k_q   <= k_q + bbfe_pkg::TERM_CNT_W'(1);
    end
    if (cmd_i.term_from_mul) begin
      term_q <= mul_p;
    end else if (cmd_i.term_from_next) begin
      term_q <= pq_q + div_quo;
    end
    if (cmd_i.pq_load) begin
      pq_q <= mul_p;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      value_q  <= (cmd_i.out_status == bbfe_pkg::STATUS_ZERO_DIV) ? '0 : div_quo;
    end
  end

  always_comb begin
    stat_o.den_zero  = (den_q == '0);
    stat_o.term_zero = (term_q == '0);
    stat_o.d_zero    = (d_q == '0);
    stat_o.k_max     = (k_q == bbfe_pkg::TERM_CNT_W'(bbfe_pkg::MAX_TERMS));
    stat_o.mul_done  = mul_done;
    stat_o.div_done  = div_done;
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

// ===== sv/bbfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbfe_ctrl
// Sequencer for the series: starts multiplies and divides in order, checks
// the stop conditions and hands the result to the output register.
// ----------------------------------------------------------------------------
module bbfe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bbfe_pkg::dp_stat_t stat_i,
  output bbfe_pkg::dp_cmd_t  cmd_o
);

  bbfe_pkg::state_e  state_q, state_d;
  bbfe_pkg::status_e status_q, status_d;
  logic              out_valid_q, out_valid_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbfe_pkg::ST_IDLE;
      status_q    <= bbfe_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = (state_q == bbfe_pkg::ST_IDLE);

    // result beat taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bbfe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_num     = 1'b1;
          cmd_o.clear_series = 1'b1;
          if (stat_i.den_zero) begin
            status_d = bbfe_pkg::STATUS_ZERO_DIV;
            state_d  = bbfe_pkg::ST_OUT;
          end else begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = bbfe_pkg::MUL_FACTOR_DEN;
            state_d         = bbfe_pkg::ST_INIT_MUL;
          end
        end
      end
      bbfe_pkg::ST_INIT_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.term_from_mul = 1'b1;
          state_d             = bbfe_pkg::ST_CHECK;
        end
      end
      bbfe_pkg::ST_CHECK: begin
        // series ends on a zero term or at the term limit
        if (stat_i.term_zero || stat_i.k_max) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = bbfe_pkg::DIV_SUM_DEN;
          status_d        = stat_i.term_zero ? bbfe_pkg::STATUS_OK
                                             : bbfe_pkg::STATUS_TERM_LIMIT;
          state_d         = bbfe_pkg::ST_DIV_SUM;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = bbfe_pkg::ST_TEST_D;
        end
      end
      bbfe_pkg::ST_TEST_D: begin
        // term divisor wrapped to zero
        if (stat_i.d_zero) begin
          status_d = bbfe_pkg::STATUS_ZERO_DIV;
          state_d  = bbfe_pkg::ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = bbfe_pkg::DIV_TERM_D;
          state_d         = bbfe_pkg::ST_DIV_Q;
        end
      end
      bbfe_pkg::ST_DIV_Q: begin
        if (stat_i.div_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = bbfe_pkg::MUL_QUO_NUM;
          state_d         = bbfe_pkg::ST_MUL_Q;
        end
      end
      bbfe_pkg::ST_MUL_Q: begin
        if (stat_i.mul_done) begin
          cmd_o.pq_load   = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = bbfe_pkg::MUL_REM_NUM;
          state_d         = bbfe_pkg::ST_MUL_R;
        end
      end
      bbfe_pkg::ST_MUL_R: begin
        if (stat_i.mul_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = bbfe_pkg::DIV_PROD_D;
          state_d         = bbfe_pkg::ST_DIV_R;
        end
      end
      bbfe_pkg::ST_DIV_R: begin
        if (stat_i.div_done) begin
          cmd_o.term_from_next = 1'b1;
          state_d              = bbfe_pkg::ST_CHECK;
        end
      end
      bbfe_pkg::ST_DIV_SUM: begin
        if (stat_i.div_done) begin
          state_d = bbfe_pkg::ST_OUT;
        end
      end
      bbfe_pkg::ST_OUT: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = status_q;
          out_valid_d      = 1'b1;
          state_d          = bbfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/blob_base_fee_exponential.sv =====
// ----------------------------------------------------------------------------
// blob_base_fee_exponential
// Integer Taylor-series approximation of factor * e^(numerator / divisor)
// as used by the blob base fee rule, with term limit and zero divisor flags.
//
// Usage:
//   cfg channel: register 0 is the factor, register 1 the divisor; other
//   indexes are ignored. cfg_ready_o is always high; write only while idle.
//   in channel: one 64-bit numerator per beat; the unit takes one item at a
//   time and in_ready_o is high only while no series is running.
//   out channel: one beat per item with approx_value_o and status_o.
// Sequence: one multiply forms the first term; each series term then
//   takes two divides in the bit-serial divider, two multiplies in the
//   32x32 multiplier and two check states, and a final divide by the
//   divisor ends the series. A zero divisor skips the series and goes
//   straight to the output register.
// Throughput: one item per full series evaluation.
// Reset: factor returns to 1 and divisor to 3338477, no result pending.
// Stall: a finished result sits in the output register; the next item is
//   taken meanwhile, and its result waits until the pending beat leaves.
// ----------------------------------------------------------------------------
module blob_base_fee_exponential (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbfe_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bbfe_pkg::DATA_W-1:0]    exponent_numerator_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bbfe_pkg::DATA_W-1:0]    approx_value_o,
  output logic [1:0]                     status_o
);

  bbfe_pkg::dp_cmd_t  cmd;
  bbfe_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bbfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bbfe_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .num_i       (exponent_numerator_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_o     (approx_value_o),
    .status_o    (status_o)
  );

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a series is running");

  // multiplier and divider are never launched together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiplier and divider started in the same cycle");

  // zero divisor results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bbfe_pkg::STATUS_ZERO_DIV |-> approx_value_o == '0)
    else $error("zero divisor result with nonzero value");

endmodule

// ===== sim/bbfe_checker.sv =====
// ----------------------------------------------------------------------------
// bbfe_checker
// Watches the register, numerator and result channels of the blob base fee
// exponential unit, computes each fee from its own copy of the factor and
// divisor, and compares every result beat in order with the oldest fee due.
// ----------------------------------------------------------------------------
module bbfe_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bbfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbfe_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [bbfe_pkg::DATA_W-1:0]    exponent_numerator_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [bbfe_pkg::DATA_W-1:0]    approx_value_i,
  input  logic [1:0]                     status_i,
  output int                             mismatch_count_o,
  output int                             fees_pending_o
);

  typedef logic [bbfe_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t             value;
    bbfe_pkg::status_e status;
  } fee_result_t;

  fee_result_t expected_fees[$];
  word_t       fee_factor  = bbfe_pkg::FACTOR_RESET;
  word_t       fee_divisor = bbfe_pkg::FEE_UPDATE_FRACTION;
  int          mismatches  = 0;
  int          pending     = 0;

  assign mismatch_count_o = mismatches;
  assign fees_pending_o   = pending;

  // taylor series of factor * e^(num / divisor), every step wraps at 64 bits
  function automatic fee_result_t eval_fee_series(word_t num, word_t factor,
                                                  word_t divisor);
    fee_result_t res;
    word_t       term;
    word_t       sum;
    word_t       d;
    word_t       q;
    word_t       r;
    int unsigned k;
    res.value  = '0;
    res.status = bbfe_pkg::STATUS_OK;
    if (divisor == '0) begin
      res.status = bbfe_pkg::STATUS_ZERO_DIV;
      return res;
    end
    term = factor * divisor;
    sum  = '0;
    k    = 0;
    while (term != '0) begin
      // series still running after the last allowed term
      if (k >= bbfe_pkg::MAX_TERMS) begin
        res.value  = sum / divisor;
        res.status = bbfe_pkg::STATUS_TERM_LIMIT;
        return res;
      end
      sum = sum + term;
      k++;
      d = divisor * word_t'(k);
      // divisor times term index wrapped to zero
      if (d == '0) begin
        res.status = bbfe_pkg::STATUS_ZERO_DIV;
        return res;
      end
      q    = term / d;
      r    = term % d;
      term = q * num + (r * num) / d;
    end
    res.value = sum / divisor;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("[%0t] check failed: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // sample all three channels on the rising edge
  always @(posedge clk_i) begin
    fee_result_t want;
    if (!rst_ni) begin
      fee_factor  = bbfe_pkg::FACTOR_RESET;
      fee_divisor = bbfe_pkg::FEE_UPDATE_FRACTION;
      expected_fees.delete();
    end else begin
      // register write beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bbfe_pkg::REG_FACTOR:  fee_factor = cfg_data_i;
          bbfe_pkg::REG_DIVISOR: fee_divisor = cfg_data_i;
          default: ;
        endcase
      end
      // result beat against the oldest fee due
      if (out_valid_i && out_ready_i) begin
        if (expected_fees.size() == 0) begin
          report_mismatch("result beat with nothing due, value", approx_value_i, '0);
        end else begin
          want = expected_fees.pop_front();
          if (approx_value_i !== want.value)
            report_mismatch("approx_value", approx_value_i, want.value);
          if (status_i !== want.status)
            report_mismatch("status", word_t'(status_i), word_t'(want.status));
        end
      end
      // numerator beat
      if (in_valid_i && in_ready_i)
        expected_fees.push_back(eval_fee_series(exponent_numerator_i, fee_factor,
                                                fee_divisor));
    end
    pending = expected_fees.size();
  end

endmodule

// ===== sim/blob_base_fee_exponential_tb.sv =====
// ----------------------------------------------------------------------------
// blob_base_fee_exponential_tb
// Drives register writes and numerators into the blob base fee exponential
// unit: directed extremes first (zero factor, zero and wrapping divisors,
// term limit, ignored indexes), then random numerators under changing
// settings and idling patterns, with a long result hold-off. The checker
// beside the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module blob_base_fee_exponential_tb;

  typedef logic [bbfe_pkg::DATA_W-1:0] word_t;

  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int DRAIN_CYCLES    = 300;
  localparam int HOLD_OFF_CYCLES = 5000;
  localparam int PHASE_ITEMS     = 95;

  // indexes past the register file, writes there must be ignored
  localparam logic [bbfe_pkg::CFG_IDX_W-1:0] REG_SPARE = bbfe_pkg::CFG_IDX_W'(2);
  localparam logic [bbfe_pkg::CFG_IDX_W-1:0] REG_TOP   = '1;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bbfe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  word_t                          cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  word_t                          numerator = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  word_t                          approx_value;
  logic [1:0]                     status;

  int    mismatches;
  int    fees_pending;
  int    sender_idle_pct = 0;
  int    recv_stall_pct  = 0;
  int    hold_off_req    = 0;
  int    items_sent      = 0;
  int    reg_writes      = 0;
  int    quiet_cycles    = 0;
  word_t cur_divisor     = bbfe_pkg::FEE_UPDATE_FRACTION;

  blob_base_fee_exponential DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .exponent_numerator_i (numerator),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .approx_value_o       (approx_value),
    .status_o             (status)
  );

  bbfe_checker u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .exponent_numerator_i (numerator),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .approx_value_i       (approx_value),
    .status_i             (status),
    .mismatch_count_o     (mismatches),
    .fees_pending_o       (fees_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then one that spans several series terms
  function automatic int gap_length();
    return ($urandom_range(9) == 0) ? $urandom_range(50, 600) : $urandom_range(1, 6);
  endfunction

  // one register write beat, valid dropped on the next falling edge
  task automatic write_reg(input logic [bbfe_pkg::CFG_IDX_W-1:0] idx, input word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == bbfe_pkg::REG_DIVISOR) cur_divisor = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one numerator beat, then maybe an idle gap
  task automatic send_numerator(input word_t num);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    numerator <= num;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = gap_length();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and wait until every fee has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (fees_pending != 0) @(negedge clk);
  endtask

  // random factor and divisor, sized so most series end in a few dozen terms
  task automatic choose_fee_setting();
    word_t factor;
    word_t divisor;
    case ($urandom_range(3))
      0: begin
        factor  = bbfe_pkg::FACTOR_RESET;
        divisor = bbfe_pkg::FEE_UPDATE_FRACTION;
      end
      1: begin
        factor  = word_t'($urandom_range(1, 1000));
        divisor = word_t'($urandom_range(1, 65535));
      end
      2: begin
        factor  = word_t'($urandom_range(0, 3));
        divisor = word_t'($urandom_range(1, 255)) << $urandom_range(8, 40);
      end
      default: begin
        factor  = word_t'($urandom_range(1, 1 << 20));
        divisor = word_t'($urandom_range(1, 4096));
      end
    endcase
    write_reg(bbfe_pkg::REG_FACTOR, factor);
    write_reg(bbfe_pkg::REG_DIVISOR, divisor);
  endtask

  // result side: random stalls, or one long hold-off on request
  initial begin : receiver
    int stretch;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        out_ready <= 1'b0;
        stretch = hold_off_req;
        hold_off_req = 0;
        repeat (stretch - 1) @(negedge clk);
      end else if ($urandom_range(99) < recv_stall_pct) begin
        out_ready <= 1'b0;
        stretch = gap_length();
        repeat (stretch - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d fees outstanding",
                 quiet_cycles, fees_pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    word_t num;
    int    sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fee rule settings straight out of reset
    send_numerator('0);
    send_numerator(word_t'(1));
    send_numerator(bbfe_pkg::FEE_UPDATE_FRACTION);
    send_numerator(word_t'(393216) * 6);
    send_numerator(bbfe_pkg::FEE_UPDATE_FRACTION * 10);
    settle();

    // writes past the register file leave the settings alone
    write_reg(REG_TOP, '1);
    write_reg(REG_SPARE, '0);
    send_numerator(bbfe_pkg::FEE_UPDATE_FRACTION);
    settle();

    // zero factor, first term already zero
    write_reg(bbfe_pkg::REG_FACTOR, '0);
    send_numerator(word_t'(12345));
    settle();

    // zero divisor register
    write_reg(bbfe_pkg::REG_FACTOR, bbfe_pkg::FACTOR_RESET);
    write_reg(bbfe_pkg::REG_DIVISOR, '0);
    send_numerator('0);
    send_numerator(word_t'(99));
    settle();

    // largest factor, unit divisor: full scale result and a runaway series
    write_reg(bbfe_pkg::REG_FACTOR, '1);
    write_reg(bbfe_pkg::REG_DIVISOR, word_t'(1));
    send_numerator('0);
    send_numerator('1);
    settle();

    // divisor times term index wraps to zero on the second term
    write_reg(bbfe_pkg::REG_FACTOR, bbfe_pkg::FACTOR_RESET);
    write_reg(bbfe_pkg::REG_DIVISOR, word_t'(1) << (bbfe_pkg::DATA_W - 1));
    send_numerator(word_t'(5));
    send_numerator('0);
    settle();

    // largest divisor
    write_reg(bbfe_pkg::REG_DIVISOR, '1);
    send_numerator(word_t'(5));
    send_numerator('1);
    settle();

    // exponent far above one, runs into the term limit
    write_reg(bbfe_pkg::REG_FACTOR, word_t'(3));
    write_reg(bbfe_pkg::REG_DIVISOR, word_t'(1));
    send_numerator(word_t'(1000));
    settle();

    // long result hold-off while numerators keep coming
    write_reg(bbfe_pkg::REG_FACTOR, bbfe_pkg::FACTOR_RESET);
    write_reg(bbfe_pkg::REG_DIVISOR, bbfe_pkg::FEE_UPDATE_FRACTION);
    @(posedge clk);
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (5) send_numerator(bbfe_pkg::FEE_UPDATE_FRACTION / 2 +
                              word_t'($urandom_range(0, 1 << 20)));
    settle();

    // random numerators: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      choose_fee_setting();
      @(posedge clk);
      sender_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 38 : 0;
      recv_stall_pct  = (ph == 2) ? 55 : (ph == 3) ? 38 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          settle();
          choose_fee_setting();
        end
        sel = $urandom_range(199);
        if (sel < 120)
          num = (cur_divisor * word_t'($urandom_range(0, 512))) >> 8;
        else if (sel < 160)
          num = word_t'($urandom_range(0, 15));
        else if (sel < 199)
          num = cur_divisor * word_t'($urandom_range(0, 3)) + word_t'($urandom_range(0, 3));
        else
          num = {$urandom, $urandom};
        send_numerator(num);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d numerators and %0d register writes: extremes, zero and wrapped",
             items_sent, reg_writes);
    $display("divisors, term limit, random settings under four idling patterns and a hold-off");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
